@@ hw/rtl/rbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants of the run-length bitset combiner
// Kinds, set operations, segment and record layouts, and the sizes of the
// record queue.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned LEN_BITS    = 16;
    localparam int unsigned REC_MAX     = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned NUM_BITS    = $clog2(REC_MAX + 1);
    // The queue takes a segment only while this many words at most are held.
    localparam int unsigned ROOM_LIMIT  = QUEUE_DEPTH - REC_MAX;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_MIXED = 2'd1,
        KIND_FULL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_AND    = 2'd0,
        OP_OR     = 2'd1,
        OP_ANDNOT = 2'd2,
        OP_XOR    = 2'd3
    } t_set_op;

    typedef enum logic {
        REC_RUN  = 1'b0,
        REC_QUAD = 1'b1
    } t_rec_kind;

    typedef struct packed {
        logic [1:0]           a_kind;
        logic [1:0]           b_kind;
        logic [WORD_BITS-1:0] a_word;
        logic [WORD_BITS-1:0] b_word;
        logic [LEN_BITS-1:0]  seg_length;
        logic                 last_segment;
    } t_seg;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        t_kind                kind;
        logic [LEN_BITS-1:0]  len;
        logic                 last;
    } t_eval;

    typedef struct packed {
        t_rec_kind            rec_kind;
        t_kind                run_kind;
        logic [LEN_BITS-1:0]  run_length;
        logic [WORD_BITS-1:0] quad_word;
        logic                 last;
    } t_rec;

    typedef struct packed {
        logic [NUM_BITS-1:0] count;
        t_rec [REC_MAX-1:0]  rec;
    } t_push;

endpackage

@@ hw/rtl/rbs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_if: handshake channels of the run-length bitset combiner
// Segment input, record output and the operation register write channel.
// ----------------------------------------------------------------------------
interface rbs_seg_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    a_kind;
    logic [1:0]                    b_kind;
    logic [rbs_pkg::WORD_BITS-1:0] a_word;
    logic [rbs_pkg::WORD_BITS-1:0] b_word;
    logic [rbs_pkg::LEN_BITS-1:0]  seg_length;
    logic                          last_segment;

    modport source (output valid, a_kind, b_kind, a_word, b_word, seg_length,
                    last_segment, input ready);
    modport sink (input valid, a_kind, b_kind, a_word, b_word, seg_length,
                  last_segment, output ready);
endinterface

interface rbs_rec_if;
    logic                          valid;
    logic                          ready;
    logic                          rec_kind;
    logic [1:0]                    run_kind;
    logic [rbs_pkg::LEN_BITS-1:0]  run_length;
    logic [rbs_pkg::WORD_BITS-1:0] quad_word;
    logic                          last;

    modport source (output valid, rec_kind, run_kind, run_length, quad_word, last,
                    input ready);
    modport sink (input valid, rec_kind, run_kind, run_length, quad_word, last,
                  output ready);
endinterface

interface rbs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/rbs_seg_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_seg_eval: segment evaluation
// Expands both sides to words, applies the set operation, classifies the
// result and works out how many quads the segment covers.
// ----------------------------------------------------------------------------
module rbs_seg_eval (
    input  rbs_pkg::t_seg    i_seg,
    input  rbs_pkg::t_set_op i_op,
    output rbs_pkg::t_eval   o_eval
);

    logic [rbs_pkg::WORD_BITS-1:0] a_val;
    logic [rbs_pkg::WORD_BITS-1:0] b_val;
    logic [rbs_pkg::WORD_BITS-1:0] res;
    logic                          any_mixed;

    always_comb begin
        // Bit one set means full, which also covers the unused code three.
        a_val = i_seg.a_kind[1] ? '1 : (i_seg.a_kind[0] ? i_seg.a_word : '0);
        b_val = i_seg.b_kind[1] ? '1 : (i_seg.b_kind[0] ? i_seg.b_word : '0);
        any_mixed = (i_seg.a_kind == rbs_pkg::KIND_MIXED) ||
                    (i_seg.b_kind == rbs_pkg::KIND_MIXED);

        case (i_op)
            rbs_pkg::OP_AND:    res = a_val & b_val;
            rbs_pkg::OP_OR:     res = a_val | b_val;
            rbs_pkg::OP_ANDNOT: res = a_val & ~b_val;
            rbs_pkg::OP_XOR:    res = a_val ^ b_val;
            default:            res = a_val ^ b_val;
        endcase

        o_eval.word = res;
        if (res == '0) begin
            o_eval.kind = rbs_pkg::KIND_EMPTY;
        end else if (res == '1) begin
            o_eval.kind = rbs_pkg::KIND_FULL;
        end else begin
            o_eval.kind = rbs_pkg::KIND_MIXED;
        end
        o_eval.len  = any_mixed ? rbs_pkg::LEN_BITS'(1) : i_seg.seg_length;
        o_eval.last = i_seg.last_segment;
    end

endmodule

@@ hw/rtl/rbs_run_ctl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_run_ctl: open run tracking
// Holds the open run, merges results of equal kind into it and forms the
// closed run, quad word and final run words of one segment, packed in order.
// ----------------------------------------------------------------------------
module rbs_run_ctl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbs_pkg::t_eval i_eval,
    input  logic           i_take,
    output rbs_pkg::t_push o_push
);

    logic                         r_open;
    rbs_pkg::t_kind               r_kind;
    logic [rbs_pkg::LEN_BITS-1:0] r_len;
    logic                         n_open;
    rbs_pkg::t_kind               n_kind;
    logic [rbs_pkg::LEN_BITS-1:0] n_len;

    logic                         len_nz;
    logic                         match;
    logic [rbs_pkg::LEN_BITS:0]   sum;
    logic [rbs_pkg::LEN_BITS-1:0] sat_len;
    logic                         mid_open;
    rbs_pkg::t_kind               mid_kind;
    logic [rbs_pkg::LEN_BITS-1:0] mid_len;
    rbs_pkg::t_rec                cand [rbs_pkg::REC_MAX];
    logic [rbs_pkg::REC_MAX-1:0]  cand_v;
    logic [rbs_pkg::NUM_BITS-1:0] num;

    always_comb begin
        len_nz  = |i_eval.len;
        match   = r_open && (r_kind == i_eval.kind);
        sum     = {1'b0, r_len} + {1'b0, i_eval.len};
        sat_len = sum[rbs_pkg::LEN_BITS] ? '1 : sum[rbs_pkg::LEN_BITS-1:0];

        // Run state after merging, before any flush.
        mid_open = r_open || len_nz;
        mid_kind = len_nz ? i_eval.kind : r_kind;
        mid_len  = !len_nz ? r_len : (match ? sat_len : i_eval.len);

        cand[0] = '{rec_kind: rbs_pkg::REC_RUN, run_kind: r_kind, run_length: r_len,
                    quad_word: '0, last: 1'b0};
        cand_v[0] = len_nz && r_open && !match;

        cand[1] = '{rec_kind: rbs_pkg::REC_QUAD, run_kind: rbs_pkg::KIND_MIXED,
                    run_length: rbs_pkg::LEN_BITS'(1), quad_word: i_eval.word,
                    last: 1'b0};
        cand_v[1] = len_nz && (i_eval.kind == rbs_pkg::KIND_MIXED);

        // A flush with nothing open still emits an empty final run of length zero.
        cand[2] = '{rec_kind: rbs_pkg::REC_RUN,
                    run_kind: mid_open ? mid_kind : rbs_pkg::KIND_EMPTY,
                    run_length: mid_open ? mid_len : '0,
                    quad_word: '0, last: 1'b1};
        cand_v[2] = i_eval.last;

        o_push.rec = '0;
        num = '0;
        for (int k = 0; k < rbs_pkg::REC_MAX; k++) begin
            if (cand_v[k]) begin
                o_push.rec[num] = cand[k];
                num = num + rbs_pkg::NUM_BITS'(1);
            end
        end
        o_push.count = num;

        if (i_eval.last) begin
            n_open = 1'b0;
            n_kind = rbs_pkg::KIND_EMPTY;
            n_len  = '0;
        end else begin
            n_open = mid_open;
            n_kind = mid_kind;
            n_len  = mid_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_kind <= rbs_pkg::KIND_EMPTY;
            r_len  <= '0;
        end else if (i_take) begin
            r_open <= n_open;
            r_kind <= n_kind;
            r_len  <= n_len;
        end
    end

endmodule

@@ hw/rtl/rbs_rec_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_rec_queue: output word queue
// Takes up to three words at once and hands them out one per handshake.
// ----------------------------------------------------------------------------
module rbs_rec_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbs_pkg::t_push i_push,
    input  logic           i_push_en,
    output logic           o_room,
    rbs_rec_if.source      o_rec
);

    rbs_pkg::t_rec                r_mem [rbs_pkg::QUEUE_DEPTH];
    logic [rbs_pkg::PTR_BITS-1:0] r_wr;
    logic [rbs_pkg::PTR_BITS-1:0] r_rd;
    logic [rbs_pkg::CNT_BITS-1:0] r_cnt;
    logic [rbs_pkg::PTR_BITS-1:0] n_wr;
    logic [rbs_pkg::PTR_BITS-1:0] n_rd;
    logic [rbs_pkg::CNT_BITS-1:0] n_cnt;
    logic                         pop;
    logic [rbs_pkg::CNT_BITS-1:0] add;
    rbs_pkg::t_rec                head;

    always_comb begin
        head             = r_mem[r_rd];
        o_rec.valid      = (r_cnt != '0);
        o_rec.rec_kind   = head.rec_kind;
        o_rec.run_kind   = head.run_kind;
        o_rec.run_length = head.run_length;
        o_rec.quad_word  = head.quad_word;
        o_rec.last       = head.last;

        pop    = o_rec.valid && o_rec.ready;
        o_room = (r_cnt <= rbs_pkg::CNT_BITS'(rbs_pkg::ROOM_LIMIT));
        add    = i_push_en ? rbs_pkg::CNT_BITS'(i_push.count) : '0;
        n_wr   = r_wr + add[rbs_pkg::PTR_BITS-1:0];
        n_rd   = r_rd + rbs_pkg::PTR_BITS'(pop);
        n_cnt  = r_cnt + add - rbs_pkg::CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < rbs_pkg::REC_MAX; k++) begin
            if (i_push_en && (rbs_pkg::NUM_BITS'(k) < i_push.count)) begin
                r_mem[r_wr + rbs_pkg::PTR_BITS'(k)] <= i_push.rec[k];
            end
        end
    end

endmodule

@@ hw/rtl/rle_bitset_set_operation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_bitset_set_operation: run-length bitset combiner, top level
// The block takes one segment per cycle while each segment yields at most one
// output word and the record side takes each word; a segment of two or three
// words (a closed run, a mixed quad word, a final run) holds the input until
// the four-word output queue, one word out per handshake, has room. A word
// goes through the input register, then the queue. The set operation register
// must be written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rle_bitset_set_operation (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbs_cfg_if.sink   i_cfg,
    rbs_seg_if.sink   i_seg,
    rbs_rec_if.source o_rec
);

    rbs_pkg::t_set_op r_set_op;
    rbs_pkg::t_seg    r_in;
    logic             r_in_valid;
    rbs_pkg::t_eval   eval;
    rbs_pkg::t_push   push;
    logic             room;
    logic             take;

    assign i_cfg.ready = 1'b1;
    assign take        = r_in_valid && room;
    assign i_seg.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_op <= rbs_pkg::OP_AND;
        end else if (i_cfg.valid) begin
            r_set_op <= rbs_pkg::t_set_op'(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_seg.ready) begin
            r_in_valid <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seg.valid && i_seg.ready) begin
            r_in <= '{a_kind: i_seg.a_kind, b_kind: i_seg.b_kind,
                      a_word: i_seg.a_word, b_word: i_seg.b_word,
                      seg_length: i_seg.seg_length,
                      last_segment: i_seg.last_segment};
        end
    end

    rbs_seg_eval u_eval (
        .i_seg  (r_in),
        .i_op   (r_set_op),
        .o_eval (eval)
    );

    rbs_run_ctl u_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_eval  (eval),
        .i_take  (take),
        .o_push  (push)
    );

    rbs_rec_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_en (take),
        .o_room    (room),
        .o_rec     (o_rec)
    );

endmodule

@@ test/rle_bitset_set_operation_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_bitset_set_operation_tb: self-checking bench of the run-length combiner
// Segments go in through the segment channel, and every set operation is
// selected through the operation channel while the block is idle. A predictor
// in the bench tracks the open run and queues the records each segment should
// produce. The record channel is checked word by word against that queue.
// Both sides insert random gaps, and at one point the record side holds off
// for a long stretch.
// ----------------------------------------------------------------------------
module rle_bitset_set_operation_tb;

    import rbs_pkg::*;

    class run_record_predictor;
        t_set_op     set_op;
        logic        run_open;
        t_kind       open_kind;
        logic [15:0] open_length;
        t_rec        pending_records[$];
        int unsigned mismatches;

        function new();
            set_op      = OP_AND;
            run_open    = 1'b0;
            open_kind   = KIND_EMPTY;
            open_length = '0;
            mismatches  = 0;
        endfunction

        function logic [31:0] side_bits(logic [1:0] kind, logic [31:0] bits);
            // The upper kind bit means full, so kind code three is full as well.
            if (kind[1])
                return '1;
            if (kind[0])
                return bits;
            return '0;
        endfunction

        function void push_record(t_rec_kind rk, t_kind kind, logic [15:0] len,
                                  logic [31:0] bits, logic is_last);
            t_rec r;
            r.rec_kind   = rk;
            r.run_kind   = kind;
            r.run_length = len;
            r.quad_word  = bits;
            r.last       = is_last;
            pending_records.push_back(r);
        endfunction

        function void absorb_segment(t_seg s);
            logic [31:0] a_bits;
            logic [31:0] b_bits;
            logic [31:0] res;
            logic [15:0] len;
            logic [16:0] total;
            t_kind       kind;
            a_bits = side_bits(s.a_kind, s.a_word);
            b_bits = side_bits(s.b_kind, s.b_word);
            if (s.a_kind == KIND_MIXED || s.b_kind == KIND_MIXED)
                len = 16'd1;
            else
                len = s.seg_length;
            case (set_op)
                OP_AND:    res = a_bits & b_bits;
                OP_OR:     res = a_bits | b_bits;
                OP_ANDNOT: res = a_bits & ~b_bits;
                default:   res = a_bits ^ b_bits;
            endcase
            if (res == '0)
                kind = KIND_EMPTY;
            else if (&res)
                kind = KIND_FULL;
            else
                kind = KIND_MIXED;

            if (len != 0) begin
                if (run_open && open_kind == kind) begin
                    total       = open_length + len;
                    open_length = (total > 17'h0FFFF) ? 16'hFFFF : total[15:0];
                end else begin
                    if (run_open)
                        push_record(REC_RUN, open_kind, open_length, '0, 1'b0);
                    run_open    = 1'b1;
                    open_kind   = kind;
                    open_length = len;
                end
                if (kind == KIND_MIXED)
                    push_record(REC_QUAD, KIND_MIXED, 16'd1, res, 1'b0);
            end

            if (s.last_segment) begin
                if (run_open)
                    push_record(REC_RUN, open_kind, open_length, '0, 1'b1);
                else
                    push_record(REC_RUN, KIND_EMPTY, 16'd0, '0, 1'b1);
                run_open    = 1'b0;
                open_kind   = KIND_EMPTY;
                open_length = '0;
            end
        endfunction

        function void check_record(t_rec got);
            t_rec want;
            if (pending_records.size() == 0) begin
                $error("record with no expectation: rec_kind %0d run_kind %0d length %0d",
                       got.rec_kind, got.run_kind, got.run_length);
                mismatches++;
                return;
            end
            want = pending_records.pop_front();
            if (got.rec_kind !== want.rec_kind) begin
                $error("rec_kind: expected %0d, got %0d", want.rec_kind, got.rec_kind);
                mismatches++;
            end
            if (got.run_kind !== want.run_kind) begin
                $error("run_kind: expected %0d, got %0d", want.run_kind, got.run_kind);
                mismatches++;
            end
            if (got.run_length !== want.run_length) begin
                $error("run_length: expected %0d, got %0d", want.run_length,
                       got.run_length);
                mismatches++;
            end
            if (got.quad_word !== want.quad_word) begin
                $error("quad_word: expected %08h, got %08h", want.quad_word,
                       got.quad_word);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rbs_seg_if seg_bus ();
    rbs_rec_if rec_bus ();
    rbs_cfg_if cfg_bus ();

    run_record_predictor predictor = new();

    bit seg_gaps_on  = 1'b1;
    bit rec_gaps_on  = 1'b1;
    bit hold_request = 1'b0;

    rle_bitset_set_operation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_seg   (seg_bus),
        .o_rec   (rec_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every handshake is observed here, so the predictor sees words in clock order.
    always @(posedge i_clk) begin
        t_seg s;
        t_rec r;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready)
                predictor.set_op = t_set_op'(cfg_bus.data);
            if (seg_bus.valid && seg_bus.ready) begin
                s.a_kind       = seg_bus.a_kind;
                s.b_kind       = seg_bus.b_kind;
                s.a_word       = seg_bus.a_word;
                s.b_word       = seg_bus.b_word;
                s.seg_length   = seg_bus.seg_length;
                s.last_segment = seg_bus.last_segment;
                predictor.absorb_segment(s);
            end
            if (rec_bus.valid && rec_bus.ready) begin
                r.rec_kind   = t_rec_kind'(rec_bus.rec_kind);
                r.run_kind   = t_kind'(rec_bus.run_kind);
                r.run_length = rec_bus.run_length;
                r.quad_word  = rec_bus.quad_word;
                r.last       = rec_bus.last;
                predictor.check_record(r);
            end
        end
    end

    // Record side: a random gap before each word, or a long hold when asked.
    initial begin
        int gap;
        rec_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = rec_gaps_on ? $urandom_range(0, 3) : 0;
            if (hold_request) begin
                gap          = 60;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                @(negedge i_clk);
                rec_bus.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rec_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rec_bus.valid);
        end
    end

    function automatic t_seg make_segment(logic [1:0] ak, logic [1:0] bk,
                                          logic [31:0] aw, logic [31:0] bw,
                                          logic [15:0] len, logic is_last);
        t_seg s;
        s.a_kind       = ak;
        s.b_kind       = bk;
        s.a_word       = aw;
        s.b_word       = bw;
        s.seg_length   = len;
        s.last_segment = is_last;
        return s;
    endfunction

    function automatic logic [1:0] draw_kind();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 5)
            return KIND_EMPTY;
        if (sel < 10)
            return KIND_MIXED;
        if (sel < 15)
            return KIND_FULL;
        return 2'b11;
    endfunction

    function automatic logic [31:0] draw_bits();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic t_seg random_segment();
        t_seg s;
        int   sel;
        s.a_kind = draw_kind();
        s.b_kind = draw_kind();
        s.a_word = draw_bits();
        s.b_word = draw_bits();
        sel = $urandom_range(0, 19);
        if (sel == 0)
            s.seg_length = '0;
        else if (sel == 1)
            s.seg_length = 16'($urandom_range(0, 16'hFFFF));
        else if (sel == 2)
            s.seg_length = 16'($urandom_range(30000, 34816));
        else
            s.seg_length = 16'($urandom_range(1, 12));
        s.last_segment = ($urandom_range(0, 7) == 0);
        return s;
    endfunction

    task automatic send_segment(t_seg s);
        int gap;
        gap = seg_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            seg_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        seg_bus.valid        <= 1'b1;
        seg_bus.a_kind       <= s.a_kind;
        seg_bus.b_kind       <= s.b_kind;
        seg_bus.a_word       <= s.a_word;
        seg_bus.b_word       <= s.b_word;
        seg_bus.seg_length   <= s.seg_length;
        seg_bus.last_segment <= s.last_segment;
        do @(posedge i_clk); while (!seg_bus.ready);
    endtask

    // Stop offering segments and wait until every expected record is out; the
    // extra cycles cover segments that are still in flight but yield nothing.
    task automatic settle_block();
        @(negedge i_clk);
        seg_bus.valid <= 1'b0;
        while (predictor.pending_records.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_set_op(t_set_op op);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= op;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        t_set_op extra_ops [3];
        t_set_op random_ops [5];
        t_seg    s;
        extra_ops  = '{OP_OR, OP_ANDNOT, OP_XOR};
        random_ops = '{OP_XOR, OP_OR, OP_ANDNOT, OP_AND, OP_XOR};

        seg_bus.valid        = 1'b0;
        seg_bus.a_kind       = '0;
        seg_bus.b_kind       = '0;
        seg_bus.a_word       = '0;
        seg_bus.b_word       = '0;
        seg_bus.seg_length   = '0;
        seg_bus.last_segment = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.data         = OP_AND;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_set_op(OP_AND);
        // Flush with no run open, then a full run that saturates its length.
        send_segment(make_segment(KIND_EMPTY, KIND_EMPTY, '0, '0, 16'd0, 1'b1));
        send_segment(make_segment(2'b11, 2'b11, '0, '0, 16'hFFFF, 1'b0));
        send_segment(make_segment(KIND_FULL, KIND_FULL, '1, '0, 16'd34816, 1'b0));
        send_segment(make_segment(KIND_MIXED, KIND_FULL, '0, '0, 16'd9, 1'b0));
        send_segment(make_segment(KIND_MIXED, KIND_MIXED, '1, '1, 16'd0, 1'b0));
        send_segment(make_segment(KIND_MIXED, KIND_MIXED, 32'hA5A5_5A5A,
                                  32'hFFFF_0000, 16'd3, 1'b0));
        // A zero-length segment without mixed sides leaves the open run alone.
        send_segment(make_segment(KIND_EMPTY, KIND_EMPTY, '1, '1, 16'd0, 1'b0));
        send_segment(make_segment(KIND_MIXED, KIND_FULL, 32'h0123_4567, '0,
                                  16'd1, 1'b1));
        foreach (extra_ops[k]) begin
            settle_block();
            write_set_op(extra_ops[k]);
            send_segment(make_segment(KIND_FULL, KIND_EMPTY, '0, '0, 16'd5, 1'b0));
            send_segment(make_segment(KIND_MIXED, KIND_FULL, 32'h0F0F_0F0F, '0,
                                      16'd2, 1'b0));
            send_segment(make_segment(KIND_EMPTY, 2'b11, '0, '0, 16'd7, 1'b0));
            send_segment(make_segment(KIND_MIXED, KIND_MIXED, 32'h1234_5678,
                                      32'hFFFF_0000, 16'd4, 1'b1));
        end

        for (int p = 0; p < 5; p++) begin
            settle_block();
            write_set_op(random_ops[p]);
            seg_gaps_on = (p != 1 && p != 2);
            rec_gaps_on = (p != 2);
            // The record side stalls long enough for the block to back up.
            if (p == 1)
                hold_request = 1'b1;
            for (int i = 0; i < 40; i++) begin
                if (p == 3 && i == 20)
                    settle_block();
                s = random_segment();
                if (i == 39)
                    s.last_segment = 1'b1;
                send_segment(s);
            end
        end

        seg_gaps_on = 1'b1;
        rec_gaps_on = 1'b1;
        settle_block();
        repeat (10) @(posedge i_clk);
        if (predictor.mismatches == 0 && predictor.pending_records.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_if.sv
hw/rtl/rbs_seg_eval.sv
hw/rtl/rbs_run_ctl.sv
hw/rtl/rbs_rec_queue.sv
hw/rtl/rle_bitset_set_operation.sv
test/rle_bitset_set_operation_tb.sv
